[rtl/hashed_page_table_insert_unit_macros.svh]
// Assertion macros shared by the hashed page table insert unit.
// No dependencies; included by the files that carry assertions.
`ifndef HASHED_PAGE_TABLE_INSERT_UNIT_MACROS_SVH
`define HASHED_PAGE_TABLE_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hpt_pkg.sv]
// Types and constants for the hashed page table insert unit.
// No dependencies; imported by hpt_slot_pick, the top level and the testbench.
package hpt_pkg;

  localparam int unsigned HASH_W = 19;
  localparam int unsigned VSID_W = 24;
  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = 3;

  typedef struct packed {
    logic [31:0] segment_word;
    logic [19:0] effective_page;
    logic [19:0] physical_page;
    logic [3:0]  wimg_bits;
    logic [1:0]  protect_bits;
  } hpt_req_t;

  typedef struct packed {
    logic        inserted;
    logic        used_secondary;
    logic [15:0] entry_byte_offset;
    logic [31:0] entry_high_word;
    logic [31:0] entry_low_word;
  } hpt_rsp_t;

  // Outcome of one free-slot search over a group's valid byte.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [SLOTS-1:0]  new_mask;
  } hpt_pick_t;

endpackage

[rtl/hpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/hpt_slot_pick.sv]
// Lowest-free-slot search over one group's valid byte, shared by both groups.
// Depends on hpt_pkg.
module hpt_slot_pick (
  input  logic [hpt_pkg::SLOTS-1:0] mask,
  output hpt_pkg::hpt_pick_t        pick
);
  import hpt_pkg::*;

  always_comb begin
    pick.found    = 1'b0;
    pick.slot     = '0;
    pick.new_mask = mask;
    // scan from the top so the lowest free slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!mask[i]) begin
        pick.found    = 1'b1;
        pick.slot     = SLOT_W'(i);
        pick.new_mask = mask | (SLOTS'(1) << i);
      end
    end
  end

endmodule

[rtl/hashed_page_table_insert_unit.sv]
// Channel   | Handshake             | Payload
// ----------+-----------------------+-------------------
// item in   | start && !busy        | request (hpt_req_t)
// result    | done, one cycle       | result  (hpt_rsp_t)
//
// An item whose primary group has a free slot ends in ST_PICK_P, one that falls
// through to the secondary group goes on to ST_PICK_S: one valid-byte read of the
// group RAM per group, each followed by a pick and a write-back.
// After reset a clearing pass in ST_CLEAR zeroes all 2^(TABLE_LOG2_BYTES-6)
// groups of the valid RAM; busy stays high throughout.
// The result strobe cannot be held off; the next item may start in its cycle.
//
// Top level of the hashed page table insert unit.
// Depends on hpt_pkg, hpt_ram, hpt_slot_pick and the macros header.
`include "hashed_page_table_insert_unit_macros.svh"

module hashed_page_table_insert_unit #(
  parameter int unsigned TABLE_LOG2_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hpt_pkg::hpt_req_t request,
  output logic              done,
  output hpt_pkg::hpt_rsp_t result
);
  import hpt_pkg::*;

  localparam int unsigned GIDX_W      = TABLE_LOG2_BYTES - 6;
  localparam int unsigned GROUP_COUNT = 1 << GIDX_W;
  localparam int unsigned OFF_W       = GIDX_W + 6;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_PICK_P = 4'b0100,
    ST_PICK_S = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [GIDX_W-1:0] clr_idx;
  hpt_req_t          item;

  logic [HASH_W-1:0] in_hash, item_hash;
  logic [GIDX_W-1:0] pri_group, sec_group, cur_group;
  logic              ram_we;
  logic [GIDX_W-1:0] ram_waddr, ram_raddr;
  logic [SLOTS-1:0]  ram_wdata, ram_rdata;
  hpt_pick_t         pick;
  logic              is_sec;
  logic [OFF_W-1:0]  offset_full;
  hpt_rsp_t          found_rsp;
  logic              accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign in_hash   = request.segment_word[HASH_W-1:0]
                   ^ {3'b000, request.effective_page[15:0]};
  assign item_hash = item.segment_word[HASH_W-1:0]
                   ^ {3'b000, item.effective_page[15:0]};
  assign pri_group = item_hash[GIDX_W-1:0];
  assign sec_group = ~item_hash[GIDX_W-1:0];
  assign is_sec    = (state == ST_PICK_S);
  assign cur_group = is_sec ? sec_group : pri_group;

  hpt_ram #(
    .WIDTH (SLOTS),
    .DEPTH (GROUP_COUNT)
  ) u_valid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hpt_slot_pick u_pick (
    .mask (ram_rdata),
    .pick (pick)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_group;
    ram_wdata = pick.new_mask;
    ram_raddr = in_hash[GIDX_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = in_hash[GIDX_W-1:0];
      end
      ST_PICK_P: begin
        ram_we    = pick.found;
        ram_raddr = sec_group;
      end
      ST_PICK_S: begin
        ram_we = pick.found;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == '1) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_PICK_P;
      ST_PICK_P: state_next = pick.found ? ST_IDLE : ST_PICK_S;
      ST_PICK_S: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  assign offset_full = {cur_group, pick.slot, 3'b000};

  always_comb begin
    found_rsp.inserted          = 1'b1;
    found_rsp.used_secondary    = is_sec;
    found_rsp.entry_byte_offset = offset_full[15:0];
    found_rsp.entry_high_word   = {1'b1, item.segment_word[VSID_W-1:0], is_sec,
                                   item.effective_page[15:10]};
    found_rsp.entry_low_word    = {item.physical_page, 3'b000, 1'b0, 1'b0,
                                   item.wimg_bits, 1'b0, item.protect_bits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      done <= (state == ST_PICK_P && pick.found) || state == ST_PICK_S;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= request;
    end
    if (state == ST_PICK_P || state == ST_PICK_S) begin
      // both groups full reports an all-zero result
      result <= pick.found ? found_rsp : '0;
    end
  end

  `HPT_ASSERT_NEXT(a_done_after_pick, clk, rst,
    (state == ST_PICK_S) || (state == ST_PICK_P && pick.found), done,
    "result strobe missing after a final pick")
  `HPT_ASSERT_NOW(a_insert_wrote, clk, rst,
    done && result.inserted, $past(ram_we),
    "inserted result without a valid-byte write")
  `HPT_ASSERT_NOW(a_fail_zero, clk, rst,
    done && !result.inserted,
    result.used_secondary == 1'b0 && result.entry_high_word == 32'd0,
    "failed insert carries non-zero fields")
  `HPT_ASSERT_NEXT(a_primary_full, clk, rst,
    state == ST_PICK_P && !pick.found, state == ST_PICK_S && !done,
    "full primary group did not move to the secondary search")

endmodule

[dv/hashed_page_table_insert_unit_tb.sv]
// Self-checking testbench for the hashed page table insert unit.
// Needs hpt_pkg and the RTL of hashed_page_table_insert_unit; reads no files.
// Keeps a shadow of the slot valid map to predict every inserted entry.
module hashed_page_table_insert_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpt_pkg::*;

  localparam int unsigned TABLE_LOG2_BYTES = 16;
  localparam int unsigned GROUP_BITS       = TABLE_LOG2_BYTES - 6;
  localparam int unsigned STALL_LIMIT      = 6000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned RANDOM_PER_PHASE = 211;

  // Shadow of the valid map, queue of predicted entries and the checker.
  class page_table_shadow #(int unsigned GBITS = 10);
    logic [SLOTS-1:0] valid_map [1 << GBITS];
    hpt_rsp_t         expected_entries [$];
    int unsigned      errors;

    function new();
      foreach (valid_map[g]) valid_map[g] = '0;
      errors = 0;
    endfunction

    function hpt_rsp_t predict_insert(hpt_req_t req);
      hpt_rsp_t          rsp;
      logic [HASH_W-1:0] hash;
      logic [HASH_W-1:0] hv;
      logic [GBITS-1:0]  group;
      logic [31:0]       offset;
      rsp  = '0;
      hash = req.segment_word[HASH_W-1:0] ^ {3'b000, req.effective_page[15:0]};
      for (int h = 0; h < 2; h++) begin
        hv    = (h != 0) ? ~hash : hash;
        group = hv[GBITS-1:0];
        for (int s = 0; s < SLOTS; s++) begin
          if (!valid_map[group][s]) begin
            valid_map[group][s] = 1'b1;
            offset = (32'(group) << 6) | (32'(s) << 3);
            rsp.inserted          = 1'b1;
            rsp.used_secondary    = (h != 0);
            rsp.entry_byte_offset = offset[15:0];
            rsp.entry_high_word   = {1'b1, req.segment_word[VSID_W-1:0], rsp.used_secondary,
                                     req.effective_page[15:10]};
            rsp.entry_low_word    = {req.physical_page, 3'b000, 1'b0, 1'b0,
                                     req.wimg_bits, 1'b0, req.protect_bits};
            return rsp;
          end
        end
      end
      // both groups full: all-zero result, map untouched
      return rsp;
    endfunction

    function void note_insert(hpt_req_t req);
      expected_entries.push_back(predict_insert(req));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%08h expected 0x%08h", name, got, want));
    endtask

    task check_result(hpt_rsp_t got);
      hpt_rsp_t want;
      if (expected_entries.size() == 0) begin
        report($sformatf("result 0x%h with no item outstanding", got));
        return;
      end
      want = expected_entries.pop_front();
      compare_field("inserted", 32'(got.inserted), 32'(want.inserted));
      compare_field("used_secondary", 32'(got.used_secondary), 32'(want.used_secondary));
      compare_field("entry_byte_offset", 32'(got.entry_byte_offset),
                    32'(want.entry_byte_offset));
      compare_field("entry_high_word", got.entry_high_word, want.entry_high_word);
      compare_field("entry_low_word", got.entry_low_word, want.entry_low_word);
    endtask

    function int unsigned pending();
      return expected_entries.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  hpt_req_t request;
  logic     done;
  hpt_rsp_t result;

  page_table_shadow #(GROUP_BITS) shadow;
  int unsigned idle_pct;
  int unsigned stall_count;
  logic [GROUP_BITS-1:0] hot_groups [4];

  hashed_page_table_insert_unit #(
    .TABLE_LOG2_BYTES(TABLE_LOG2_BYTES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  // Predict on acceptance, check on the strobe.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) shadow.note_insert(request);
      if (done) shadow.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Leaves start high on return; the caller lowers it once stimulus is over.
  task send_item(hpt_req_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Steer about half the items at a few hot groups so that pairs fill up.
  function hpt_req_t random_item();
    hpt_req_t req;
    req.segment_word   = $urandom;
    req.effective_page = 20'($urandom);
    req.physical_page  = 20'($urandom);
    req.wimg_bits      = 4'($urandom);
    req.protect_bits   = 2'($urandom);
    if ($urandom_range(99) < 55)
      req.effective_page[GROUP_BITS-1:0] =
        req.segment_word[GROUP_BITS-1:0] ^ hot_groups[$urandom_range(3)];
    return req;
  endfunction

  initial begin
    hpt_req_t req;
    shadow      = new();
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    idle_pct    = 26;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill group 0 and its secondary, then two inserts that find both full.
    for (int i = 0; i < 18; i++) begin
      if (i == 0) begin
        req = '0;
      end else if (i == 1) begin
        req = '1;
      end else begin
        req.segment_word   = $urandom;
        req.effective_page = 20'($urandom);
        req.effective_page[GROUP_BITS-1:0] = req.segment_word[GROUP_BITS-1:0];
        req.physical_page  = (i % 2 == 0) ? 20'hFFFFF : 20'h00000;
        req.wimg_bits      = 4'(i);
        req.protect_bits   = 2'(i);
      end
      send_item(req);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 26 : (phase == 1) ? 85 : 0;
      foreach (hot_groups[k]) hot_groups[k] = GROUP_BITS'($urandom);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_item(random_item());
    end
    start <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.pending() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.pending()));

    if (shadow.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
